@@ src/lcim_pkg.sv @@
`timescale 1ns / 1ps

package lcim_pkg;

  // default build choices
  localparam int MAX_CYCLES_DEF = 3;
  localparam int MAX_SKIP_DEF   = 3;
  localparam int DISC_FLOOR     = 1;
  localparam int SAMPLE_FLOOR   = 2;

  // struct fields are sized for the widest parameter setting
  localparam int CYC_W  = 4;
  localparam int SKIP_W = 3;

  localparam logic [31:0] CLOCK_HZ      = 32'd16_000_000;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  // port geometry
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 136;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;

  // shared divider
  localparam int QW         = 80;
  localparam int DIVL_STEPS = 80;
  localparam int DIVF_STEPS = 32;
  localparam int STEP_W     = $clog2(DIVL_STEPS + 1);

  localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_CAPTURE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REF_ONLY   = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEFF   = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_MUL   = 2'd1,
    OP_DLOAD = 2'd2,
    OP_DSTEP = 2'd3
  } lcim_op_t;

  // end of a measurement, handed to the sequencer
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [31:0]         time_span;
    logic [CYC_W-1:0]    cycles;
    logic [SKIP_W-1:0]   discard;
  } lcim_fin_t;

endpackage

@@ src/lcim_arith.sv @@
`timescale 1ns / 1ps

module lcim_arith (
  input  logic                     clk,
  input  lcim_pkg::lcim_op_t       op,
  input  logic [31:0]              mul_a,
  input  logic [31:0]              mul_b,
  input  logic [lcim_pkg::QW-1:0]  div_dividend,
  input  logic [31:0]              div_divisor,
  output logic [63:0]              prod,
  output logic [lcim_pkg::QW-1:0]  quo
);
  import lcim_pkg::*;

  logic [63:0]   prod_r;
  logic [QW-1:0] quo_r;
  logic [31:0]   rem_r;
  logic [31:0]   div_r;
  logic [32:0]   trial;
  logic [32:0]   diff;
  logic          fits;

  // restoring divide, one quotient bit per step, shifted in at the bottom
  assign trial = {rem_r, quo_r[QW-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = ~diff[32];

  always_ff @(posedge clk) begin
    case (op)
      OP_MUL: begin
        prod_r <= 64'(mul_a) * 64'(mul_b);
      end
      OP_DLOAD: begin
        quo_r <= div_dividend;
        rem_r <= '0;
        div_r <= div_divisor;
      end
      OP_DSTEP: begin
        quo_r <= {quo_r[QW-2:0], fits};
        rem_r <= fits ? diff[31:0] : trial[31:0];
      end
      default: ;
    endcase
  end

  assign prod = prod_r;
  assign quo  = quo_r;

endmodule

@@ src/lcim_meas.sv @@
`timescale 1ns / 1ps

module lcim_meas #(
  parameter int MAX_CYCLES = lcim_pkg::MAX_CYCLES_DEF,
  parameter int MAX_SKIP   = lcim_pkg::MAX_SKIP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  input  logic [lcim_pkg::CMD_W-1:0]  command,
  input  logic [15:0]                 capture_value,
  input  logic [7:0]                  overflow_count,
  input  logic [15:0]                 timeout_ticks,
  output lcim_pkg::lcim_fin_t         fin
);
  import lcim_pkg::*;

  localparam int CW = $clog2(MAX_CYCLES + 1);
  localparam int DW = $clog2(MAX_SKIP + 1);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_REF  = 3'b010,
    PH_COL  = 3'b100
  } phase_t;

  phase_t         phase_r, phase_nxt;
  logic [2:0]     seen_r, seen_nxt;
  logic [CW-1:0]  cyc_r, cyc_nxt;
  logic [15:0]    elapsed_r, elapsed_nxt;
  logic [15:0]    ref_cap_r, ref_cap_nxt;
  logic [7:0]     ref_ovf_r, ref_ovf_nxt;
  logic [15:0]    end_cap_r, end_cap_nxt;
  logic [7:0]     last_ovf_r, last_ovf_nxt;
  logic [DW-1:0]  disc_r, disc_nxt;

  logic [2:0]          seen_inc;
  logic [CW-1:0]       cyc_inc;
  logic [15:0]         el_inc;
  logic [15:0]         src_cap;
  logic [7:0]          src_ovf;
  logic [7:0]          ovf_diff;
  logic [31:0]         span;
  logic                done;
  logic [STATUS_W-1:0] end_status;
  logic [CW-1:0]       end_cycles;

  assign seen_inc = (seen_r != 3'd7) ? seen_r + 3'd1 : seen_r;
  assign cyc_inc  = cyc_r + CW'(1);
  assign el_inc   = (elapsed_r != 16'hFFFF) ? elapsed_r + 16'd1 : elapsed_r;

  // a capture that ends the run brings its own timestamp as the last one
  assign src_cap  = (command == CMD_CAPTURE) ? capture_value : end_cap_r;
  assign src_ovf  = (command == CMD_CAPTURE) ? overflow_count : last_ovf_r;
  assign ovf_diff = src_ovf - ref_ovf_r;
  assign span     = {16'd0, src_cap} - {16'd0, ref_cap_r} + {8'd0, ovf_diff, 16'd0};

  always_comb begin
    phase_nxt    = phase_r;
    seen_nxt     = seen_r;
    cyc_nxt      = cyc_r;
    elapsed_nxt  = elapsed_r;
    ref_cap_nxt  = ref_cap_r;
    ref_ovf_nxt  = ref_ovf_r;
    end_cap_nxt  = end_cap_r;
    last_ovf_nxt = last_ovf_r;
    disc_nxt     = disc_r;
    done         = 1'b0;
    end_status   = ST_OK;
    end_cycles   = cyc_r;

    if (item_valid) begin
      case (command)
        CMD_START: begin
          phase_nxt   = PH_REF;
          seen_nxt    = '0;
          cyc_nxt     = '0;
          elapsed_nxt = '0;
        end
        CMD_CAPTURE: begin
          if (phase_r != PH_IDLE) begin
            seen_nxt = seen_inc;
            if (phase_r == PH_REF) begin
              if (int'(seen_inc) >= int'(disc_r)) begin
                ref_cap_nxt  = capture_value;
                ref_ovf_nxt  = overflow_count;
                end_cap_nxt  = capture_value;
                last_ovf_nxt = overflow_count;
                cyc_nxt      = '0;
                elapsed_nxt  = '0;
                phase_nxt    = PH_COL;
              end
            end else begin
              cyc_nxt      = cyc_inc;
              end_cap_nxt  = capture_value;
              last_ovf_nxt = overflow_count;
              if (int'(cyc_inc) >= MAX_CYCLES) begin
                done       = 1'b1;
                end_cycles = cyc_inc;
              end
            end
          end
        end
        CMD_TICK: begin
          if (phase_r != PH_IDLE) begin
            elapsed_nxt = el_inc;
            if (el_inc >= timeout_ticks) begin
              done = 1'b1;
              if (phase_r == PH_REF) begin
                end_status = ST_NO_CAPTURE;
              end else if (cyc_r == '0) begin
                end_status = ST_REF_ONLY;
              end
            end
          end
        end
        default: ;
      endcase
    end

    fin            = '0;
    fin.status     = end_status;
    if (done) begin
      phase_nxt = PH_IDLE;
      fin.valid = 1'b1;
      if (end_status == ST_OK) begin
        fin.time_span = span;
        fin.cycles    = CYC_W'(end_cycles);
        if (int'(end_cycles) > SAMPLE_FLOOR && int'(disc_r) < MAX_SKIP) begin
          disc_nxt = disc_r + DW'(1);
        end
      end else if (int'(disc_r) > DISC_FLOOR) begin
        disc_nxt = disc_r - DW'(1);
      end
    end
    fin.discard = SKIP_W'(disc_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      seen_r     <= '0;
      cyc_r      <= '0;
      elapsed_r  <= '0;
      ref_cap_r  <= '0;
      ref_ovf_r  <= '0;
      end_cap_r  <= '0;
      last_ovf_r <= '0;
      disc_r     <= DW'(DISC_FLOOR);
    end else begin
      phase_r    <= phase_nxt;
      seen_r     <= seen_nxt;
      cyc_r      <= cyc_nxt;
      elapsed_r  <= elapsed_nxt;
      ref_cap_r  <= ref_cap_nxt;
      ref_ovf_r  <= ref_ovf_nxt;
      end_cap_r  <= end_cap_nxt;
      last_ovf_r <= last_ovf_nxt;
      disc_r     <= disc_nxt;
    end
  end

  a_cyc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_COL |-> int'(cyc_r) < MAX_CYCLES)
    else $error("cycle count reached its limit without ending the run");

  a_disc_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(disc_r) >= DISC_FLOOR && int'(disc_r) <= MAX_SKIP)
    else $error("discard count left its adaptation range");

  a_ref_reached: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_COL |-> int'(seen_r) >= int'(disc_r))
    else $error("collecting before the reference capture was reached");

endmodule

@@ src/lc_ringing_inductance_meter.sv @@
`timescale 1ns / 1ps

// LC ringing inductance meter.
// Input stream: in_tuser carries the command (start, capture, tick), in_tdata the
// timer value and overflow count of a capture. Starts, captures and ticks that do
// not end a measurement are taken one per cycle, back to back, while in_tready is high.
// A measurement ends on the last capture of a run or on a phase timeout; that
// transaction produces one result on the output stream (status in out_tuser).
// An ok result with nonzero time runs through one shared 32x32 multiplier and
// one shift-subtract divider: three multiplies, an 80-step divide for the
// inductance and a 32-step divide for the frequency, so in_tready stays low through
// the multiplies and divides, and the result appears as it rises again.
// Other results skip the multiplier and divider.
// Results sit in an output register; the next item is accepted while a result
// waits. If the receiver stalls and another result is due, the block holds that
// result and keeps in_tready low until the output register frees up.
// Configuration (timeout_ticks at index 0, inductance_coeff at index 1) is written
// through cfg_we/cfg_addr/cfg_wdata; the user must write it only while the block
// is idle; the block does not enforce it. Reset (rst_n low, synchronous) returns
// to idle with discard count 1, timeout 500, coefficient 0, and drops any pending result.

module lc_ringing_inductance_meter #(
  parameter int MAX_CYCLES = lcim_pkg::MAX_CYCLES_DEF,
  parameter int MAX_SKIP   = lcim_pkg::MAX_SKIP_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lcim_pkg::CMD_W-1:0]       in_tuser,  // command
  input  logic [lcim_pkg::IN_DATA_W-1:0]   in_tdata,  // capture_value, overflow_count
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lcim_pkg::STATUS_W-1:0]    out_tuser, // status
  // total time, cycle_count, frequency_hz, inductance_pico, discard_level, zero pad
  output logic [lcim_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_we,
  input  logic [lcim_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [lcim_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lcim_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SQ    = 9'b000000010,
    S_MLO   = 9'b000000100,
    S_MHI   = 9'b000001000,
    S_LOADL = 9'b000010000,
    S_DIVL  = 9'b000100000,
    S_LOADF = 9'b001000000,
    S_DIVF  = 9'b010000000,
    S_DONE  = 9'b100000000
  } seq_t;

  logic [15:0] timeout_r;
  logic [31:0] coeff_r;

  seq_t                state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [31:0]         t_r, t_nxt;
  logic [CYC_W-1:0]    n_r, n_nxt;
  logic [SKIP_W-1:0]   disc_r, disc_nxt;
  logic [31:0]         sq_hi_r, sq_hi_nxt;
  logic [63:0]         pa_r, pa_nxt;
  logic [63:0]         ind_r, ind_nxt;
  logic [31:0]         freq_r, freq_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic            in_accept;
  lcim_fin_t       fin;
  lcim_op_t        op;
  logic [31:0]     mul_a;
  logic [31:0]     mul_b;
  logic [QW-1:0]   div_dividend;
  logic [31:0]     div_divisor;
  logic [63:0]     prod;
  logic [QW-1:0]   quo;
  logic [95:0]     wide_sum;
  logic [2*CYC_W-1:0] n_sq;
  logic [31:0]     freq_num;

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      coeff_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TIMEOUT: timeout_r <= cfg_wdata[15:0];
        REG_COEFF:   coeff_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lcim_meas #(
    .MAX_CYCLES (MAX_CYCLES),
    .MAX_SKIP   (MAX_SKIP)
  ) u_meas (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (in_accept),
    .command        (in_tuser),
    .capture_value  (in_tdata[15:0]),
    .overflow_count (in_tdata[23:16]),
    .timeout_ticks  (timeout_r),
    .fin            (fin)
  );

  lcim_arith u_arith (
    .clk          (clk),
    .op           (op),
    .mul_a        (mul_a),
    .mul_b        (mul_b),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .prod         (prod),
    .quo          (quo)
  );

  // coeff * t^2 from its two partial products, then drop the Q16 fraction
  assign wide_sum = {prod, 32'd0} + {32'd0, pa_r};
  assign n_sq     = {{CYC_W{1'b0}}, n_r} * {{CYC_W{1'b0}}, n_r};
  assign freq_num = 32'(n_r) * CLOCK_HZ;

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    res_status_nxt = res_status_r;
    t_nxt          = t_r;
    n_nxt          = n_r;
    disc_nxt       = disc_r;
    sq_hi_nxt      = sq_hi_r;
    pa_nxt         = pa_r;
    ind_nxt        = ind_r;
    freq_nxt       = freq_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    op             = OP_NONE;
    mul_a          = t_r;
    mul_b          = t_r;
    div_dividend   = '0;
    div_divisor    = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept && fin.valid) begin
          res_status_nxt = fin.status;
          t_nxt          = fin.time_span;
          n_nxt          = fin.cycles;
          disc_nxt       = fin.discard;
          ind_nxt        = '0;
          freq_nxt       = '0;
          if (fin.status == ST_OK && fin.time_span != '0) begin
            state_nxt = S_SQ;
          end else begin
            // zero time saturates the frequency
            if (fin.status == ST_OK) begin
              freq_nxt = '1;
            end
            state_nxt = S_DONE;
          end
        end
      end
      S_SQ: begin
        op        = OP_MUL;
        state_nxt = S_MLO;
      end
      S_MLO: begin
        op        = OP_MUL;
        mul_a     = prod[31:0];
        mul_b     = coeff_r;
        sq_hi_nxt = prod[63:32];
        state_nxt = S_MHI;
      end
      S_MHI: begin
        op        = OP_MUL;
        mul_a     = sq_hi_r;
        mul_b     = coeff_r;
        pa_nxt    = prod;
        state_nxt = S_LOADL;
      end
      S_LOADL: begin
        op           = OP_DLOAD;
        div_dividend = wide_sum[95:16];
        div_divisor  = 32'(n_sq);
        step_nxt     = STEP_W'(DIVL_STEPS);
        state_nxt    = S_DIVL;
      end
      S_DIVL: begin
        op       = OP_DSTEP;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          state_nxt = S_LOADF;
        end
      end
      S_LOADF: begin
        ind_nxt      = (|quo[QW-1:64]) ? '1 : quo[63:0];
        op           = OP_DLOAD;
        div_dividend = {freq_num, {(QW-32){1'b0}}};
        div_divisor  = t_r;
        step_nxt     = STEP_W'(DIVF_STEPS);
        state_nxt    = S_DIVF;
      end
      S_DIVF: begin
        op       = OP_DSTEP;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          // the frequency quotient is ready here when the divides ran
          out_data_nxt   = {4'd0, disc_r[1:0], ind_r,
                            ((res_status_r == ST_OK && t_r != '0) ? quo[31:0] : freq_r),
                            n_r[1:0], t_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    res_status_r <= res_status_nxt;
    t_r          <= t_nxt;
    n_r          <= n_nxt;
    disc_r       <= disc_nxt;
    sq_hi_r      <= sq_hi_nxt;
    pa_r         <= pa_nxt;
    ind_r        <= ind_nxt;
    freq_r       <= freq_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  a_arith_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQ |-> (t_r != '0 && res_status_r == ST_OK))
    else $error("arithmetic started for a result that needs none");

  a_divl_to_f: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVL && step_r == STEP_W'(1)) |=> state_r == S_LOADF)
    else $error("inductance divide did not hand over to the frequency divide");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_data_r[129:0] == '0)
    else $error("failed measurement carries nonzero figures");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import lcim_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 150;
  localparam int PHASE_ITEMS = 175;
  localparam int NUM_SETTINGS = 5;

  typedef enum logic [1:0] {PH_IDLE, PH_WAIT_REF, PH_COLLECT} meas_phase_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [31:0]         time_span;
    logic [1:0]          cycles;
    logic [31:0]         freq_hz;
    logic [63:0]         henry_pico;
    logic [1:0]          discard;
  } meas_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [15:0]      cap;
    logic [7:0]       ovf;
    bit               typed;
    meas_t            want;
  } row_t;

  // directed part runs with timeout 1 and the largest coefficient
  row_t script [26] = '{
    '{CMD_UNUSED,  16'hFFFF, 8'hFF, 1'b0, '0},
    '{CMD_TICK,    16'h0000, 8'h00, 1'b0, '0},
    '{CMD_CAPTURE, 16'hFFFF, 8'hFF, 1'b0, '0},
    '{CMD_START,   16'h0000, 8'h00, 1'b0, '0},
    '{CMD_TICK,    16'h0000, 8'h00, 1'b1, '{ST_NO_CAPTURE, 32'd0, 2'd0, 32'd0, 64'd0, 2'd1}},
    '{CMD_START,   16'h0000, 8'h00, 1'b0, '0},
    '{CMD_CAPTURE, 16'h0000, 8'h00, 1'b0, '0},
    '{CMD_TICK,    16'h0000, 8'h00, 1'b1, '{ST_REF_ONLY, 32'd0, 2'd0, 32'd0, 64'd0, 2'd1}},
    '{CMD_START,   16'h0000, 8'h00, 1'b0, '0},
    '{CMD_CAPTURE, 16'h1234, 8'h56, 1'b0, '0},
    '{CMD_CAPTURE, 16'h1234, 8'h56, 1'b0, '0},
    '{CMD_TICK,    16'h0000, 8'h00, 1'b1,
      '{ST_OK, 32'd0, 2'd1, 32'hFFFF_FFFF, 64'd0, 2'd1}},
    '{CMD_START,   16'h0000, 8'h00, 1'b0, '0},
    '{CMD_CAPTURE, 16'h0000, 8'h00, 1'b0, '0},
    '{CMD_CAPTURE, 16'h5555, 8'hAA, 1'b0, '0},
    '{CMD_CAPTURE, 16'hAAAA, 8'h55, 1'b0, '0},
    '{CMD_CAPTURE, 16'hFFFF, 8'hFF, 1'b0, '0},
    '{CMD_START,   16'h0000, 8'h00, 1'b0, '0},
    '{CMD_CAPTURE, 16'h7777, 8'h01, 1'b0, '0},
    '{CMD_CAPTURE, 16'hFFFF, 8'h00, 1'b0, '0},
    '{CMD_CAPTURE, 16'h0000, 8'h00, 1'b0, '0},
    '{CMD_TICK,    16'h0000, 8'h00, 1'b0, '0},
    '{CMD_START,   16'h0000, 8'h00, 1'b0, '0},
    '{CMD_CAPTURE, 16'h8888, 8'h80, 1'b0, '0},
    '{CMD_START,   16'h0000, 8'h00, 1'b0, '0},
    '{CMD_TICK,    16'h0000, 8'h00, 1'b1, '{ST_NO_CAPTURE, 32'd0, 2'd0, 32'd0, 64'd0, 2'd1}}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [CMD_W-1:0]      in_tuser = CMD_UNUSED;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [STATUS_W-1:0]   out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_TIMEOUT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of the block
  logic [15:0]  tmo_ticks = TIMEOUT_RESET;
  logic [31:0]  coeff = 32'd0;
  meas_phase_t  ph = PH_IDLE;
  logic [2:0]   seen = '0;
  logic [1:0]   cyc = '0;
  logic [15:0]  elapsed = '0;
  logic [15:0]  ref_cap = '0;
  logic [7:0]   ref_ovf = '0;
  logic [15:0]  end_cap = '0;
  logic [7:0]   last_ovf = '0;
  logic [1:0]   discard = 2'(DISC_FLOOR);

  meas_t pending_meas[$];
  int    mismatches = 0;
  int    results_seen = 0;
  int    items_sent = 0;
  int    settings_used = 0;
  int    quiet_cycles = 0;
  bit    in_calm = 1'b0;
  bit    rx_calm = 1'b0;
  int    stall_left = 0;

  lc_ringing_inductance_meter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void close_measurement(logic [STATUS_W-1:0] st);
    meas_t        m;
    logic [31:0]  span;
    logic [7:0]   ovf_gap;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] quo;
    int           n;
    m = '0;
    n = cyc;
    if (st == ST_OK) begin
      ovf_gap = last_ovf - ref_ovf;
      span = 32'(end_cap) - 32'(ref_cap) + {8'd0, ovf_gap, 16'd0};
      if (span == 32'd0) begin
        m.freq_hz = 32'hFFFF_FFFF;
      end else begin
        m.freq_hz = 32'((64'(n) * 64'(CLOCK_HZ)) / 64'(span));
        num = 128'(coeff) * 128'(span) * 128'(span);
        den = 128'(n * n) << 16;
        quo = num / den;
        m.henry_pico = (quo[127:64] != '0) ? '1 : quo[63:0];
      end
      if (n > SAMPLE_FLOOR && discard < MAX_SKIP_DEF) discard = discard + 2'd1;
      m.time_span = span;
      m.cycles = 2'(n);
    end else if (discard > DISC_FLOOR) begin
      discard = discard - 2'd1;
    end
    m.status = st;
    m.discard = discard;
    ph = PH_IDLE;
    pending_meas.push_back(m);
  endfunction

  // returns 1 when the transaction ends a measurement
  function automatic bit predict_step(logic [CMD_W-1:0] cmd, logic [15:0] cap, logic [7:0] ovf);
    if (cmd == CMD_START) begin
      ph = PH_WAIT_REF;
      seen = '0;
      cyc = '0;
      elapsed = '0;
      return 1'b0;
    end
    if (cmd == CMD_CAPTURE) begin
      if (ph == PH_IDLE) return 1'b0;
      if (seen != 3'd7) seen = seen + 3'd1;
      if (ph == PH_WAIT_REF) begin
        // earlier captures are skipped until the count reaches the discard level
        if (seen >= discard) begin
          ref_cap = cap;
          ref_ovf = ovf;
          end_cap = cap;
          last_ovf = ovf;
          cyc = '0;
          elapsed = '0;
          ph = PH_COLLECT;
        end
        return 1'b0;
      end
      cyc = cyc + 2'd1;
      end_cap = cap;
      last_ovf = ovf;
      if (cyc >= MAX_CYCLES_DEF) begin
        close_measurement(ST_OK);
        return 1'b1;
      end
      return 1'b0;
    end
    if (cmd == CMD_TICK) begin
      if (ph == PH_IDLE) return 1'b0;
      if (elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
      if (elapsed < tmo_ticks) return 1'b0;
      if (ph == PH_WAIT_REF) close_measurement(ST_NO_CAPTURE);
      else close_measurement((cyc != '0) ? ST_OK : ST_REF_ONLY);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_txn(input logic [CMD_W-1:0] cmd, input logic [15:0] cap,
                          input logic [7:0] ovf, output bit made);
    int gap;
    gap = pick_gap(in_calm);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {ovf, cap};
    do @(posedge clk); while (!in_tready);
    made = predict_step(cmd, cap, ovf);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TIMEOUT) tmo_ticks = val[15:0];
    else coeff = val;
  endtask

  // block must be idle before registers change or the run ends
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_meas.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CMD_W-1:0] CMD_WIDTH_RAND();
    return CMD_W'($urandom_range(0, 3));
  endfunction

  task automatic run_measurement();
    int          kind;
    int          ncap;
    int          nend;
    int          scale;
    logic [23:0] stamp;
    bit          made;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 6) == 0) in_calm = ~in_calm;
    if (kind < 82) begin
      send_txn(CMD_START, 16'($urandom), 8'($urandom), made);
      ncap = $urandom_range(0, 6);
      scale = $urandom_range(0, 3);
      stamp = 24'($urandom);
      for (int k = 0; k < ncap; k++) begin
        if ($urandom_range(0, 99) < ((tmo_ticks <= 4) ? 8 : 25))
          send_txn(CMD_TICK, 16'($urandom), 8'($urandom), made);
        case (scale)
          0: stamp = stamp + 24'($urandom_range(1, 300));
          1: stamp = stamp + 24'($urandom_range(1, 65535));
          2: stamp = stamp + 24'($urandom);
          default: stamp = 24'($urandom);
        endcase
        send_txn(CMD_CAPTURE, stamp[15:0], stamp[23:16], made);
      end
      if (tmo_ticks <= 8 || (tmo_ticks <= 600 && $urandom_range(0, 39) == 0))
        nend = tmo_ticks;
      else
        nend = $urandom_range(0, 2);
      for (int k = 0; k < nend; k++)
        send_txn(CMD_TICK, 16'($urandom), 8'($urandom), made);
    end else begin
      repeat ($urandom_range(1, 6))
        send_txn(CMD_WIDTH_RAND(), 16'($urandom), 8'($urandom), made);
    end
  endtask

  // receiver: stalls of random length, with calm stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 399) == 0) rx_calm = ~rx_calm;
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    meas_t got;
    meas_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[31:0], out_tdata[33:32], out_tdata[65:34],
             out_tdata[129:66], out_tdata[131:130]};
      if (pending_meas.size() == 0) begin
        flag_mismatch("unexpected result, status", 64'(got.status), 64'(0));
      end else begin
        want = pending_meas.pop_front();
        if (got.status !== want.status)
          flag_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.time_span !== want.time_span)
          flag_mismatch("time span", 64'(got.time_span), 64'(want.time_span));
        if (got.cycles !== want.cycles)
          flag_mismatch("cycle_count", 64'(got.cycles), 64'(want.cycles));
        if (got.freq_hz !== want.freq_hz)
          flag_mismatch("frequency_hz", 64'(got.freq_hz), 64'(want.freq_hz));
        if (got.henry_pico !== want.henry_pico)
          flag_mismatch("inductance_pico", got.henry_pico, want.henry_pico);
        if (got.discard !== want.discard)
          flag_mismatch("discard_level", 64'(got.discard), 64'(want.discard));
      end
      results_seen++;
    end
  end

  // watchdog on cycles with no transaction on either stream
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] tmo_list [NUM_SETTINGS];
    logic [31:0] coeff_list [NUM_SETTINGS];
    bit          made;
    int          target;
    tmo_list = '{16'd60, 16'd1, 16'd65535, 16'd3, 16'd2};
    coeff_list = '{32'd0, $urandom, 32'hFFFF_FFFF, $urandom, $urandom_range(1, 65535)};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    write_reg(REG_TIMEOUT, 32'd1);
    write_reg(REG_COEFF, 32'hFFFF_FFFF);
    settings_used++;
    foreach (script[i]) begin
      send_txn(script[i].cmd, script[i].cap, script[i].ovf, made);
      if (made && script[i].typed) pending_meas[pending_meas.size() - 1] = script[i].want;
    end
    drain();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      write_reg(REG_TIMEOUT, 32'(tmo_list[s]));
      write_reg(REG_COEFF, coeff_list[s]);
      settings_used++;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_measurement();
      drain();
    end

    $display("%0d input transactions sent, %0d measurement results checked", items_sent,
             results_seen);
    $display("%0d register settings used, timeout from 1 to 65535", settings_used);
    if (mismatches == 0 && pending_meas.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ lc_ringing_inductance_meter.f @@
src/lcim_pkg.sv
src/lcim_arith.sv
src/lcim_meas.sv
src/lc_ringing_inductance_meter.sv
test/tb_top.sv
